// ----- sv/obb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and the CORDIC arctangent table for the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TRIG_BITS_DEF  = 16;

    localparam int ANG_BITS     = 16;
    localparam int OVL_BITS     = 26;
    localparam int AXIS_BITS    = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CZ_BITS      = 32;
    localparam int CW_BITS      = 34;
    localparam logic signed [CW_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

    // axis codes
    localparam logic [1:0] AXIS_AX = 2'd0;
    localparam logic [1:0] AXIS_AY = 2'd1;
    localparam logic [1:0] AXIS_BX = 2'd2;
    localparam logic [1:0] AXIS_BY = 2'd3;

    // arctangent of 2^-i, 2^30 per quarter turn
    function automatic logic signed [CZ_BITS-1:0] atan_lut(input logic [4:0] i);
        logic signed [CZ_BITS-1:0] v;
        unique case (i)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            5'd24: v = 32'sd41;
            5'd25: v = 32'sd20;
            5'd26: v = 32'sd10;
            5'd27: v = 32'sd5;
            5'd28: v = 32'sd3;
            5'd29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/obb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_in_if / obb_out_if
// Valid/ready channels carrying one box pair and one overlap result.
// ----------------------------------------------------------------------------
interface obb_in_if #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic        [COORD_BITS-2:0] a_width;
    logic        [COORD_BITS-2:0] a_height;
    logic [obb_pkg::ANG_BITS-1:0] a_angle;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic        [COORD_BITS-2:0] b_width;
    logic        [COORD_BITS-2:0] b_height;
    logic [obb_pkg::ANG_BITS-1:0] b_angle;

    modport source (output valid, a_x, a_y, a_width, a_height, a_angle,
                    b_x, b_y, b_width, b_height, b_angle, input ready);
    modport sink   (input valid, a_x, a_y, a_width, a_height, a_angle,
                    b_x, b_y, b_width, b_height, b_angle, output ready);
endinterface

interface obb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic [obb_pkg::OVL_BITS-1:0]          min_overlap;
    logic [1:0]                            axis_select;
    logic signed [obb_pkg::AXIS_BITS-1:0]  axis_dx;
    logic signed [obb_pkg::AXIS_BITS-1:0]  axis_dy;

    modport source (output valid, hit, min_overlap, axis_select, axis_dx, axis_dy,
                    input ready);
    modport sink   (input valid, hit, min_overlap, axis_select, axis_dx, axis_dy,
                    output ready);
endinterface

// ----- sv/obb_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_cordic
// Pipelined 30-stage rotation CORDIC giving rounded, clamped cos and sin.
// ----------------------------------------------------------------------------
module obb_cordic #(
    parameter int TRIG_BITS = obb_pkg::TRIG_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [obb_pkg::ANG_BITS-1:0]        i_angle,
    output logic signed [TRIG_BITS-1:0]         o_cos,
    output logic signed [TRIG_BITS-1:0]         o_sin
);
    localparam int N  = obb_pkg::CORDIC_STEPS;
    localparam int W  = obb_pkg::CW_BITS;
    localparam int ZW = obb_pkg::CZ_BITS;
    localparam int TF = TRIG_BITS - 1;
    localparam int LIM = (1 << TF) - 1;

    logic signed [W-1:0]  r_x [0:N];
    logic signed [W-1:0]  r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];

    // stage 0 load
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= obb_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= ZW'({i_angle[13:0], 16'h0000});
            r_q[0] <= i_angle[15:14];
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - obb_pkg::atan_lut(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + obb_pkg::atan_lut(5'(i));
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // quadrant fold
    logic signed [W-1:0] c_raw, s_raw;
    always_comb begin
        unique case (r_q[N])
            2'd0:    begin c_raw = r_x[N];  s_raw = r_y[N];  end
            2'd1:    begin c_raw = -r_y[N]; s_raw = r_x[N];  end
            2'd2:    begin c_raw = -r_x[N]; s_raw = -r_y[N]; end
            default: begin c_raw = r_y[N];  s_raw = -r_x[N]; end
        endcase
    end

    function automatic logic signed [TRIG_BITS-1:0] rnd(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        logic signed [W:0] r;
        t = (W+1)'(v) + ((W+1)'(1) <<< (29 - TF));
        r = t >>> (30 - TF);
        if (r > (W+1)'(LIM))       return TRIG_BITS'(LIM);
        else if (r < -(W+1)'(LIM)) return TRIG_BITS'(-LIM);
        else                       return TRIG_BITS'(r);
    endfunction

    // rounding register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= rnd(c_raw);
            o_sin <= rnd(s_raw);
        end
    end
endmodule

// ----- sv/obb_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_lane
// One axis lane: radius sum minus projected center offset, in three stages.
// ----------------------------------------------------------------------------
module obb_lane #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int TRIG_BITS  = obb_pkg::TRIG_BITS_DEF,
    parameter int OW         = 64
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [COORD_BITS-2:0]         i_own,    // own size on this axis
    input  logic [COORD_BITS-2:0]         i_s1,     // other size, times c1
    input  logic [COORD_BITS-2:0]         i_s2,     // other size, times c2
    input  logic [TRIG_BITS-1:0]          i_c1,     // non-negative
    input  logic [TRIG_BITS-1:0]          i_c2,
    input  logic signed [COORD_BITS+2:0]  i_t1,     // offset terms
    input  logic signed [COORD_BITS+2:0]  i_t2,
    input  logic signed [TRIG_BITS-1:0]   i_k1,
    input  logic signed [TRIG_BITS-1:0]   i_k2,
    output logic signed [OW-1:0]          o_ov
);
    localparam int TF = TRIG_BITS - 1;
    localparam int PW = COORD_BITS + TRIG_BITS + 3;

    // products
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= PW'({1'b0, i_own}) <<< TF;
            r_p2 <= PW'($signed({1'b0, i_s1}) * $signed({1'b0, i_c1}));
            r_p3 <= PW'($signed({1'b0, i_s2}) * $signed({1'b0, i_c2}));
            r_p4 <= PW'(i_t1 * i_k1);
            r_p5 <= PW'(i_t2 * i_k2);
        end
    end

    // sums
    logic signed [OW-1:0] r_rad, r_prj;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= OW'(r_p1) + OW'(r_p2) + OW'(r_p3);
            r_prj <= OW'(r_p4) + OW'(r_p5);
        end
    end

    // overlap
    always_ff @(posedge i_clk) begin
        if (i_en) o_ov <= r_rad - (r_prj < 0 ? -r_prj : r_prj);
    end
endmodule

// ----- sv/obb_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_merge
// Combines four lane overlaps: hit test, minimum with tie order, scaling.
// ----------------------------------------------------------------------------
module obb_merge #(
    parameter int TRIG_BITS = obb_pkg::TRIG_BITS_DEF,
    parameter int OW        = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [OW-1:0]                 i_ov [4],
    input  logic signed [TRIG_BITS-1:0]          i_dx [4],
    input  logic signed [TRIG_BITS-1:0]          i_dy [4],
    output logic                                 o_hit,
    output logic [obb_pkg::OVL_BITS-1:0]         o_min,
    output logic [1:0]                           o_sel,
    output logic signed [obb_pkg::AXIS_BITS-1:0] o_dx,
    output logic signed [obb_pkg::AXIS_BITS-1:0] o_dy
);
    localparam int TF = TRIG_BITS - 1;
    localparam int OM = (1 << obb_pkg::OVL_BITS) - 1;

    // first pairwise stage: A axes and B axes
    logic                        r_hit;
    logic signed [OW-1:0]        r_va, r_vb;
    logic [1:0]                  r_sa, r_sb;
    logic signed [TRIG_BITS-1:0] r_xa, r_ya, r_xb, r_yb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= (i_ov[0] > 0) && (i_ov[1] > 0) && (i_ov[2] > 0) && (i_ov[3] > 0);
            if (i_ov[1] < i_ov[0]) begin
                r_va <= i_ov[1]; r_sa <= obb_pkg::AXIS_AY; r_xa <= i_dx[1]; r_ya <= i_dy[1];
            end else begin
                r_va <= i_ov[0]; r_sa <= obb_pkg::AXIS_AX; r_xa <= i_dx[0]; r_ya <= i_dy[0];
            end
            if (i_ov[3] < i_ov[2]) begin
                r_vb <= i_ov[3]; r_sb <= obb_pkg::AXIS_BY; r_xb <= i_dx[3]; r_yb <= i_dy[3];
            end else begin
                r_vb <= i_ov[2]; r_sb <= obb_pkg::AXIS_BX; r_xb <= i_dx[2]; r_yb <= i_dy[2];
            end
        end
    end

    function automatic logic signed [obb_pkg::AXIS_BITS-1:0] to_q15(
        input logic signed [TRIG_BITS-1:0] v);
        logic signed [TRIG_BITS+16:0] r;
        if (TF > 15)
            r = ((TRIG_BITS+17)'(v) + ((TRIG_BITS+17)'(1) <<< (TF - 16))) >>> (TF - 15);
        else
            r = (TRIG_BITS+17)'(v) <<< (15 - TF);
        if (r > 32767)       return 16'sd32767;
        else if (r < -32767) return -16'sd32767;
        else                 return 16'(r);
    endfunction

    // final choice and output formatting
    logic signed [OW-1:0] best_v, rnd_v;
    logic [1:0]           best_s;
    logic signed [TRIG_BITS-1:0] best_x, best_y;
    always_comb begin
        if (r_vb < r_va) begin
            best_v = r_vb; best_s = r_sb; best_x = r_xb; best_y = r_yb;
        end else begin
            best_v = r_va; best_s = r_sa; best_x = r_xa; best_y = r_ya;
        end
        rnd_v = (best_v + (OW'(1) <<< TF)) >>> (TF + 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= r_hit;
            if (r_hit) begin
                o_min <= (rnd_v > OW'(OM)) ? obb_pkg::OVL_BITS'(OM)
                                           : obb_pkg::OVL_BITS'(rnd_v);
                o_sel <= best_s;
                o_dx  <= to_q15(best_x);
                o_dy  <= to_q15(best_y);
            end else begin
                o_min <= '0;
                o_sel <= obb_pkg::AXIS_AX;
                o_dx  <= '0;
                o_dy  <= '0;
            end
        end
    end
endmodule

// ----- sv/obb_overlap_separating_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_overlap_separating_axis
// Separating axis test for two rotated boxes, four axis lanes and a merge.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Depth: 32 CORDIC stages (load, 30 rotations, rounding), 3 lane and 2 merge stages.
// Reset clears only the valid pipeline; data registers are not reset.
module obb_overlap_separating_axis #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int TRIG_BITS  = obb_pkg::TRIG_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    obb_in_if.sink    i_in,
    obb_out_if.source o_out
);
    localparam int OW  = 64;
    localparam int TD  = obb_pkg::CORDIC_STEPS + 2;   // cordic latency
    localparam int LAT = TD + 3 + 2;
    localparam int CW  = COORD_BITS;

    // pipeline control: advance when output register is free or taken
    logic             en;
    logic [LAT-1:0]   r_vld;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[LAT-2:0], i_in.valid};
    end

    // trig units: A, B and the difference angle
    logic signed [TRIG_BITS-1:0] ca, sa, cb, sb, cd, sd;
    logic [obb_pkg::ANG_BITS-1:0] dang;
    assign dang = i_in.b_angle - i_in.a_angle;
    obb_cordic #(.TRIG_BITS(TRIG_BITS)) u_ta (.i_clk, .i_en(en), .i_angle(i_in.a_angle),
                                              .o_cos(ca), .o_sin(sa));
    obb_cordic #(.TRIG_BITS(TRIG_BITS)) u_tb (.i_clk, .i_en(en), .i_angle(i_in.b_angle),
                                              .o_cos(cb), .o_sin(sb));
    obb_cordic #(.TRIG_BITS(TRIG_BITS)) u_td (.i_clk, .i_en(en), .i_angle(dang),
                                              .o_cos(cd), .o_sin(sd));

    // doubled center offsets and sizes, delayed alongside the cordic
    logic signed [CW+2:0] tx, ty;
    assign tx = ((CW+3)'(i_in.a_x) <<< 1) + (CW+3)'({1'b0, i_in.a_width})
              - ((CW+3)'(i_in.b_x) <<< 1) - (CW+3)'({1'b0, i_in.b_width});
    assign ty = ((CW+3)'(i_in.a_y) <<< 1) + (CW+3)'({1'b0, i_in.a_height})
              - ((CW+3)'(i_in.b_y) <<< 1) - (CW+3)'({1'b0, i_in.b_height});

    logic signed [CW+2:0] r_tx [TD], r_ty [TD];
    logic [CW-2:0] r_aw [TD], r_ah [TD], r_bw [TD], r_bh [TD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= tx; r_ty[0] <= ty;
            r_aw[0] <= i_in.a_width;  r_ah[0] <= i_in.a_height;
            r_bw[0] <= i_in.b_width;  r_bh[0] <= i_in.b_height;
            for (int i = 1; i < TD; i++) begin
                r_tx[i] <= r_tx[i-1]; r_ty[i] <= r_ty[i-1];
                r_aw[i] <= r_aw[i-1]; r_ah[i] <= r_ah[i-1];
                r_bw[i] <= r_bw[i-1]; r_bh[i] <= r_bh[i-1];
            end
        end
    end

    // absolute cross terms (at most 2^TF - 1, fits unsigned)
    logic [TRIG_BITS-1:0] acd, asd;
    assign acd = cd[TRIG_BITS-1] ? TRIG_BITS'(-cd) : TRIG_BITS'(cd);
    assign asd = sd[TRIG_BITS-1] ? TRIG_BITS'(-sd) : TRIG_BITS'(sd);
    logic signed [TRIG_BITS-1:0] nsa, nsb;
    assign nsa = -sa;
    assign nsb = -sb;

    // four axis lanes
    logic signed [OW-1:0] ov [4];
    obb_lane #(.COORD_BITS(CW), .TRIG_BITS(TRIG_BITS), .OW(OW)) u_l0 (
        .i_clk, .i_en(en), .i_own(r_aw[TD-1]), .i_s1(r_bw[TD-1]), .i_s2(r_bh[TD-1]),
        .i_c1(acd), .i_c2(asd), .i_t1(r_tx[TD-1]), .i_t2(r_ty[TD-1]),
        .i_k1(ca), .i_k2(sa), .o_ov(ov[0]));
    obb_lane #(.COORD_BITS(CW), .TRIG_BITS(TRIG_BITS), .OW(OW)) u_l1 (
        .i_clk, .i_en(en), .i_own(r_ah[TD-1]), .i_s1(r_bw[TD-1]), .i_s2(r_bh[TD-1]),
        .i_c1(asd), .i_c2(acd), .i_t1(r_ty[TD-1]), .i_t2(r_tx[TD-1]),
        .i_k1(ca), .i_k2(nsa), .o_ov(ov[1]));
    obb_lane #(.COORD_BITS(CW), .TRIG_BITS(TRIG_BITS), .OW(OW)) u_l2 (
        .i_clk, .i_en(en), .i_own(r_bw[TD-1]), .i_s1(r_aw[TD-1]), .i_s2(r_ah[TD-1]),
        .i_c1(acd), .i_c2(asd), .i_t1(r_tx[TD-1]), .i_t2(r_ty[TD-1]),
        .i_k1(cb), .i_k2(sb), .o_ov(ov[2]));
    obb_lane #(.COORD_BITS(CW), .TRIG_BITS(TRIG_BITS), .OW(OW)) u_l3 (
        .i_clk, .i_en(en), .i_own(r_bh[TD-1]), .i_s1(r_aw[TD-1]), .i_s2(r_ah[TD-1]),
        .i_c1(asd), .i_c2(acd), .i_t1(r_ty[TD-1]), .i_t2(r_tx[TD-1]),
        .i_k1(cb), .i_k2(nsb), .o_ov(ov[3]));

    // axis vectors delayed to meet the lane outputs
    logic signed [TRIG_BITS-1:0] r_dx [3][4], r_dy [3][4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0][0] <= ca;  r_dy[0][0] <= sa;
            r_dx[0][1] <= nsa; r_dy[0][1] <= ca;
            r_dx[0][2] <= cb;  r_dy[0][2] <= sb;
            r_dx[0][3] <= nsb; r_dy[0][3] <= cb;
            for (int i = 1; i < 3; i++) begin
                r_dx[i] <= r_dx[i-1];
                r_dy[i] <= r_dy[i-1];
            end
        end
    end

    // merging stage drives the output register
    obb_merge #(.TRIG_BITS(TRIG_BITS), .OW(OW)) u_merge (
        .i_clk, .i_en(en), .i_ov(ov), .i_dx(r_dx[2]), .i_dy(r_dy[2]),
        .o_hit(o_out.hit), .o_min(o_out.min_overlap), .o_sel(o_out.axis_select),
        .o_dx(o_out.axis_dx), .o_dy(o_out.axis_dy));
endmodule

// ----- bench/obb_overlap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_overlap_checker
// Watches the box pair and result channels, computes the expected overlap
// result for each accepted box pair and compares it field by field.
// ----------------------------------------------------------------------------
module obb_overlap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obb_in_if           i_in,
    obb_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int TF = obb_pkg::TRIG_BITS_DEF - 1;

    typedef struct packed {
        logic                           hit;
        logic [obb_pkg::OVL_BITS-1:0]   ovl;
        logic [1:0]                     axis;
        logic [obb_pkg::AXIS_BITS-1:0]  dx;
        logic [obb_pkg::AXIS_BITS-1:0]  dy;
    } t_overlap_res;

    typedef struct {
        longint c;
        longint s;
    } t_sincos;

    t_overlap_res expected_q[$];
    int           fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic longint sra(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // cordic rotation in Q1.30, rounded to TF fraction bits
    function automatic t_sincos sin_cos(logic [obb_pkg::ANG_BITS-1:0] ang);
        longint xr, yr, zr, xs, ys, cc, ss;
        logic [1:0] quad;
        t_sincos r;
        xr = obb_pkg::CORDIC_GAIN;
        yr = 0;
        zr = longint'(ang[13:0]) << 16;
        quad = ang[15:14];
        for (int i = 0; i < obb_pkg::CORDIC_STEPS; i++) begin
            xs = sra(xr, i);
            ys = sra(yr, i);
            if (zr >= 0) begin
                xr -= ys; yr += xs; zr -= longint'(obb_pkg::atan_lut(5'(i)));
            end else begin
                xr += ys; yr -= xs; zr += longint'(obb_pkg::atan_lut(5'(i)));
            end
        end
        case (quad)
            2'd0: begin cc = xr;  ss = yr;  end
            2'd1: begin cc = -yr; ss = xr;  end
            2'd2: begin cc = -xr; ss = -yr; end
            default: begin cc = yr; ss = -xr; end
        endcase
        r.c = clip(sra(cc + (64'sd1 <<< (29 - TF)), 30 - TF), (64'sd1 <<< TF) - 1);
        r.s = clip(sra(ss + (64'sd1 <<< (29 - TF)), 30 - TF), (64'sd1 <<< TF) - 1);
        return r;
    endfunction

    function automatic logic [obb_pkg::AXIS_BITS-1:0] axis_q15(longint v);
        longint r;
        if (TF > 15) r = sra(v + (64'sd1 <<< (TF - 16)), TF - 15);
        else r = v <<< (15 - TF);
        r = clip(r, 32767);
        return r[obb_pkg::AXIS_BITS-1:0];
    endfunction

    function automatic t_overlap_res sat_overlap(
        longint ax, longint ay, longint aw, longint ah, logic [15:0] aang,
        longint bx, longint by, longint bw, longint bh, logic [15:0] bang);
        t_sincos ta, tb, td;
        longint one, cd, sd, tx, ty, m;
        longint ov[4], dx[4], dy[4];
        int best;
        t_overlap_res r;
        ta = sin_cos(aang);
        tb = sin_cos(bang);
        td = sin_cos(bang - aang);
        one = 64'sd1 <<< TF;
        cd = mag(td.c);
        sd = mag(td.s);
        tx = (2 * ax + aw) - (2 * bx + bw);
        ty = (2 * ay + ah) - (2 * by + bh);
        ov[0] = aw * one + bw * cd + bh * sd - mag(tx * ta.c + ty * ta.s);
        ov[1] = ah * one + bw * sd + bh * cd - mag(ty * ta.c - tx * ta.s);
        ov[2] = aw * cd + ah * sd + bw * one - mag(tx * tb.c + ty * tb.s);
        ov[3] = aw * sd + ah * cd + bh * one - mag(ty * tb.c - tx * tb.s);
        dx[0] = ta.c;  dy[0] = ta.s;
        dx[1] = -ta.s; dy[1] = ta.c;
        dx[2] = tb.c;  dy[2] = tb.s;
        dx[3] = -tb.s; dy[3] = tb.c;
        r = '0;
        for (int k = 0; k < 4; k++)
            if (ov[k] <= 0) return r;
        best = 0;
        for (int k = 1; k < 4; k++)
            if (ov[k] < ov[best]) best = k;
        m = (ov[best] + one) >>> (TF + 1);
        if (m > (64'sd1 <<< obb_pkg::OVL_BITS) - 1) m = (64'sd1 <<< obb_pkg::OVL_BITS) - 1;
        r.hit  = 1'b1;
        r.ovl  = m[obb_pkg::OVL_BITS-1:0];
        r.axis = 2'(best);
        r.dx   = axis_q15(dx[best]);
        r.dy   = axis_q15(dy[best]);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // predict on every accepted box pair, compare on every accepted result
    always @(posedge i_clk) begin
        t_overlap_res want;
        t_overlap_res pred;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            pred = sat_overlap(
                longint'(i_in.a_x), longint'(i_in.a_y),
                longint'({1'b0, i_in.a_width}), longint'({1'b0, i_in.a_height}),
                i_in.a_angle,
                longint'(i_in.b_x), longint'(i_in.b_y),
                longint'({1'b0, i_in.b_width}), longint'({1'b0, i_in.b_height}),
                i_in.b_angle);
            expected_q = {expected_q, pred};
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, pending", 0, 0);
            end else begin
                want = expected_q.pop_front();
                if (i_out.hit !== want.hit)
                    report_mismatch("hit", i_out.hit, want.hit);
                if (i_out.min_overlap !== want.ovl)
                    report_mismatch("min_overlap", i_out.min_overlap, want.ovl);
                if (i_out.axis_select !== want.axis)
                    report_mismatch("axis_select", i_out.axis_select, want.axis);
                if (i_out.axis_dx !== want.dx)
                    report_mismatch("axis_dx", i_out.axis_dx, $signed(want.dx));
                if (i_out.axis_dy !== want.dy)
                    report_mismatch("axis_dy", i_out.axis_dy, $signed(want.dy));
            end
        end
    end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives box pairs into the overlap test with random gaps and output stalls:
// directed corners first, then mostly nearby pairs plus random noise.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int N_RANDOM = 1830;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    obb_in_if  box_ch ();
    obb_out_if res_ch ();

    obb_overlap_separating_axis i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (box_ch),
        .o_out   (res_ch)
    );

    obb_overlap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (box_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #20ms;
        $display("** obb_overlap_separating_axis: FAILED **");
        $finish;
    end

    // result stalls: a random wait before each result, skipped for about one in four
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            repeat (gap) begin
                res_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_pair(logic [23:0] ax, logic [23:0] ay, logic [22:0] aw,
                             logic [22:0] ah, logic [15:0] aa, logic [23:0] bx,
                             logic [23:0] by, logic [22:0] bw, logic [22:0] bh,
                             logic [15:0] ba, int gap);
        repeat (gap) begin
            box_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        box_ch.valid    <= 1'b1;
        box_ch.a_x      <= ax;
        box_ch.a_y      <= ay;
        box_ch.a_width  <= aw;
        box_ch.a_height <= ah;
        box_ch.a_angle  <= aa;
        box_ch.b_x      <= bx;
        box_ch.b_y      <= by;
        box_ch.b_width  <= bw;
        box_ch.b_height <= bh;
        box_ch.b_angle  <= ba;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
    endtask

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    // stimulus
    initial begin
        int   n, gap, sz;
        bit   burst;
        logic [23:0] ax, ay, bx, by;
        logic [22:0] aw, ah, bw, bh;
        i_rst_n      <= 1'b0;
        box_ch.valid <= 1'b0;
        box_ch.a_x <= '0; box_ch.a_y <= '0; box_ch.a_width <= '0;
        box_ch.a_height <= '0; box_ch.a_angle <= '0;
        box_ch.b_x <= '0; box_ch.b_y <= '0; box_ch.b_width <= '0;
        box_ch.b_height <= '0; box_ch.b_angle <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identical, touching, tiny, zero size, extremes, axis ties
        send_pair(0, 0, 23'h1000, 23'h1000, 0, 0, 0, 23'h1000, 23'h1000, 0, 0);
        send_pair(0, 0, 23'h1000, 23'h1000, 0, 24'h1000, 0, 23'h1000, 23'h1000, 0, 0);
        send_pair(0, 0, 23'h1000, 23'h1000, 0, 24'h0FFF, 0, 23'h1000, 23'h1000, 0, 1);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 23'h100, 23'h100, 0, 24'h80, 24'h80, 0, 0, 16'h2000, 0);
        send_pair(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF,
                  24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'h8000, 2);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'h4000,
                  24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'hC000, 0);
        send_pair(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'h0000,
                  24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'h0000, 0);
        send_pair(24'hFFFF00, 24'hFFFF00, 23'h200, 23'h200, 16'h2000,
                  24'hFFFF80, 24'hFFFF80, 23'h100, 23'h300, 16'h6000, 0);
        send_pair(0, 0, 23'h800, 23'h400, 16'h1234, 24'h100, 24'h80, 23'h300, 23'h900,
                  16'hABCD, 3);
        send_pair(0, 0, 23'h400, 23'h400, 0, 24'h10, 24'h10, 23'h400, 23'h400, 0, 0);
        send_pair(0, 0, 23'h400, 23'h800, 16'h4000, 0, 0, 23'h800, 23'h400, 0, 0);
        send_pair(0, 0, 23'h1, 23'h1, 16'h7FFF, 0, 0, 23'h1, 23'h1, 16'h8001, 0);
        send_pair(24'h555555, 24'hAAAAAA, 23'h2AAAAA, 23'h555555, 16'h5555,
                  24'hAAAAAA, 24'h555555, 23'h555555, 23'h2AAAAA, 16'hAAAA, 0);
        send_pair(0, 0, 23'h1000, 23'h1000, 16'h2000, 24'h1000, 24'h1000, 23'h1000,
                  23'h1000, 16'hE000, 0);

        // random: mostly nearby pairs with small sizes, some full range noise
        burst = 1'b0;
        for (n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 5) burst = ~burst;
            gap = draw_gap(burst);
            if ($urandom_range(0, 9) < 2) begin
                send_pair(24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
                          16'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
                          23'($urandom), 16'($urandom), gap);
            end else begin
                sz = ($urandom_range(0, 19) == 0) ? 22 : $urandom_range(4, 16);
                ax = 24'($urandom);
                ay = 24'($urandom);
                aw = 23'($urandom_range(0, (1 << sz) - 1));
                ah = 23'($urandom_range(0, (1 << sz) - 1));
                bw = 23'($urandom_range(0, (1 << sz) - 1));
                bh = 23'($urandom_range(0, (1 << sz) - 1));
                bx = ax + 24'($signed($urandom_range(0, 1 << (sz + 1))) - (1 << sz));
                by = ay + 24'($signed($urandom_range(0, 1 << (sz + 1))) - (1 << sz));
                send_pair(ax, ay, aw, ah, 16'($urandom), bx, by, bw, bh, 16'($urandom),
                          gap);
            end
        end
        box_ch.valid <= 1'b0;

        // drain, then allow the pipeline depth to settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("** obb_overlap_separating_axis: PASSED **");
        else
            $display("** obb_overlap_separating_axis: FAILED **");
        $finish;
    end
endmodule
